// ===== sv/gtsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gtsc_pkg;

    localparam int SAMPLE_W           = 16;
    localparam int GAIN_W             = 24;
    localparam int MAG_W              = 17;
    localparam int TAB_W              = 15;
    localparam int FULL_SCALE         = 32767;
    localparam int DEF_TABLE_DEPTH    = 1024;
    localparam int DEF_GAIN_FRAC_BITS = 16;
    localparam int PIPE_LATENCY       = 8;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd65536;

    typedef struct packed {
        logic valid;
        logic neg;
        logic sat;
    } ctrl_t;

    function automatic int x_width(int depth);
        return MAG_W + $clog2(depth + 1) + GAIN_W;
    endfunction

    function automatic int addr_width(int depth);
        return $clog2(depth);
    endfunction

endpackage

`default_nettype wire

// ===== sv/gain_tanh_soft_clipper.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                          Beat taken when
// input     start, busy, sample_in         start high and busy low
// result    done, sample_out               done high (one cycle, no hold-off)
// config    cfg_valid, cfg_ready, cfg_data cfg_valid and cfg_ready high
//
// One sample enters per clock; each result leaves after its beat has crossed
// the eight register stages of the gain, index, table and interpolation path.
// busy stays low: every stage advances each cycle and no stall exists anywhere.
// Reset clears the stage valid bits and sets the gain to unity; no clearing pass.
// Write the gain only while no sample is in flight.

module gain_tanh_soft_clipper #(
    parameter int TABLE_DEPTH    = gtsc_pkg::DEF_TABLE_DEPTH,
    parameter int GAIN_FRAC_BITS = gtsc_pkg::DEF_GAIN_FRAC_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [gtsc_pkg::SAMPLE_W-1:0] sample_in,
    output logic                          done,
    output logic [gtsc_pkg::SAMPLE_W-1:0] sample_out,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [gtsc_pkg::GAIN_W-1:0]   cfg_data
);
    import gtsc_pkg::*;

    localparam int XW = x_width(TABLE_DEPTH);
    localparam int AW = addr_width(TABLE_DEPTH);
    localparam int E  = GAIN_FRAC_BITS + 3;

    logic [GAIN_W-1:0] gain_reg;
    logic              in_valid;
    ctrl_t             ctrl_x;
    ctrl_t             ctrl_i;
    ctrl_t             ctrl_t0;
    logic [XW-1:0]     x;
    logic [AW-1:0]     idx;
    logic [TAB_W-1:0]  r1_i;
    logic [TAB_W-1:0]  r1_t;
    logic [E-1:0]      low_i;
    logic [E-1:0]      low_t;
    logic [TAB_W-1:0]  t0;
    logic [TAB_W-1:0]  dt;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign in_valid  = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            gain_reg <= cfg_data;
        end
    end

    gtsc_gain_mul #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_gain_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .sample_in (sample_in),
        .gain      (gain_reg),
        .ctrl_out  (ctrl_x),
        .x_out     (x)
    );

    gtsc_index #(
        .TABLE_DEPTH    (TABLE_DEPTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_index (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl_in  (ctrl_x),
        .x_in     (x),
        .ctrl_out (ctrl_i),
        .idx      (idx),
        .r1       (r1_i),
        .low      (low_i)
    );

    gtsc_tanh_rom #(
        .TABLE_DEPTH    (TABLE_DEPTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_tanh_rom (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl_in  (ctrl_i),
        .idx      (idx),
        .r1_in    (r1_i),
        .low_in   (low_i),
        .ctrl_out (ctrl_t0),
        .t0       (t0),
        .dt       (dt),
        .r1_out   (r1_t),
        .low_out  (low_t)
    );

    gtsc_interp #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_interp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl_in    (ctrl_t0),
        .t0         (t0),
        .dt         (dt),
        .r1         (r1_t),
        .low        (low_t),
        .done       (done),
        .sample_out (sample_out)
    );

endmodule

`default_nettype wire

// ===== sv/gtsc_gain_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gtsc_gain_mul #(
    parameter int TABLE_DEPTH = gtsc_pkg::DEF_TABLE_DEPTH
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        in_valid,
    input  logic [gtsc_pkg::SAMPLE_W-1:0]               sample_in,
    input  logic [gtsc_pkg::GAIN_W-1:0]                 gain,
    output gtsc_pkg::ctrl_t                             ctrl_out,
    output logic [gtsc_pkg::x_width(TABLE_DEPTH)-1:0]   x_out
);
    import gtsc_pkg::*;

    localparam int DW  = $clog2(TABLE_DEPTH + 1);
    localparam int MDW = MAG_W + DW;
    localparam int XW  = x_width(TABLE_DEPTH);

    logic [MAG_W-1:0] mag;
    ctrl_t            ctrl1_reg;
    ctrl_t            ctrl1_next;
    ctrl_t            ctrl2_reg;
    logic [MDW-1:0]   md_reg;
    logic [MDW-1:0]   md_next;
    logic [XW-1:0]    x_reg;
    logic [XW-1:0]    x_next;

    always_comb
    begin
        mag = sample_in[SAMPLE_W-1] ? (MAG_W'(0) - {sample_in[SAMPLE_W-1], sample_in})
                                    : {1'b0, sample_in};
        ctrl1_next.valid = in_valid;
        ctrl1_next.neg   = sample_in[SAMPLE_W-1];
        ctrl1_next.sat   = 1'b0;
        md_next = MDW'(MDW'(mag) * MDW'(TABLE_DEPTH));
        x_next  = XW'(md_reg) * XW'(gain);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl1_reg <= '0;
            ctrl2_reg <= '0;
        end
        else
        begin
            ctrl1_reg <= ctrl1_next;
            ctrl2_reg <= ctrl1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        md_reg <= md_next;
        x_reg  <= x_next;
    end

    assign ctrl_out = ctrl2_reg;
    assign x_out    = x_reg;

endmodule

`default_nettype wire

// ===== sv/gtsc_index.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gtsc_index #(
    parameter int TABLE_DEPTH    = gtsc_pkg::DEF_TABLE_DEPTH,
    parameter int GAIN_FRAC_BITS = gtsc_pkg::DEF_GAIN_FRAC_BITS
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  gtsc_pkg::ctrl_t                               ctrl_in,
    input  logic [gtsc_pkg::x_width(TABLE_DEPTH)-1:0]     x_in,
    output gtsc_pkg::ctrl_t                               ctrl_out,
    output logic [gtsc_pkg::addr_width(TABLE_DEPTH)-1:0]  idx,
    output logic [gtsc_pkg::TAB_W-1:0]                    r1,
    output logic [GAIN_FRAC_BITS+2:0]                     low
);
    import gtsc_pkg::*;

    localparam int XW   = x_width(TABLE_DEPTH);
    localparam int AW   = addr_width(TABLE_DEPTH);
    localparam int E    = GAIN_FRAC_BITS + 3;
    localparam int YQ_W = TAB_W + AW + 1;
    localparam int SW   = TAB_W + 1;
    localparam logic [XW-1:0] SAT_LIM =
        (XW'(TABLE_DEPTH) * XW'(8 * FULL_SCALE)) << GAIN_FRAC_BITS;

    logic [XW-1:0]    xs;
    logic [YQ_W-1:0]  yq;
    logic [AW:0]      hi_part;
    logic [SW-1:0]    fold;
    logic             carry;
    ctrl_t            ctrl_reg;
    ctrl_t            ctrl_next;
    logic [AW-1:0]    idx_reg;
    logic [AW-1:0]    idx_next;
    logic [TAB_W-1:0] r1_reg;
    logic [TAB_W-1:0] r1_next;
    logic [E-1:0]     low_reg;

    always_comb
    begin
        xs      = x_in >> E;
        yq      = xs[YQ_W-1:0];
        hi_part = yq[YQ_W-1:TAB_W];
        fold    = SW'(hi_part) + SW'(yq[TAB_W-1:0]);
        carry   = (fold >= SW'(FULL_SCALE));
        idx_next = AW'(hi_part + (AW+1)'(carry));
        r1_next  = carry ? TAB_W'(fold - SW'(FULL_SCALE)) : TAB_W'(fold);
        ctrl_next     = ctrl_in;
        ctrl_next.sat = (x_in >= SAT_LIM);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        r1_reg  <= r1_next;
        low_reg <= x_in[E-1:0];
    end

    assign ctrl_out = ctrl_reg;
    assign idx      = idx_reg;
    assign r1       = r1_reg;
    assign low      = low_reg;

endmodule

`default_nettype wire

// ===== sv/gtsc_tanh_rom.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gtsc_tanh_rom #(
    parameter int TABLE_DEPTH    = gtsc_pkg::DEF_TABLE_DEPTH,
    parameter int GAIN_FRAC_BITS = gtsc_pkg::DEF_GAIN_FRAC_BITS
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  gtsc_pkg::ctrl_t                               ctrl_in,
    input  logic [gtsc_pkg::addr_width(TABLE_DEPTH)-1:0]  idx,
    input  logic [gtsc_pkg::TAB_W-1:0]                    r1_in,
    input  logic [GAIN_FRAC_BITS+2:0]                     low_in,
    output gtsc_pkg::ctrl_t                               ctrl_out,
    output logic [gtsc_pkg::TAB_W-1:0]                    t0,
    output logic [gtsc_pkg::TAB_W-1:0]                    dt,
    output logic [gtsc_pkg::TAB_W-1:0]                    r1_out,
    output logic [GAIN_FRAC_BITS+2:0]                     low_out
);
    import gtsc_pkg::*;

    localparam int AW    = addr_width(TABLE_DEPTH);
    localparam int ROM_N = 1 << AW;
    localparam int E     = GAIN_FRAC_BITS + 3;
    localparam logic [63:0] Q60_ONE = 64'd1 << 60;

    typedef logic [2*TAB_W-1:0] word_t;
    typedef word_t rom_t [ROM_N];

    function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
        logic [127:0] pr;
        pr = {64'd0, a} * {64'd0, b};
        return pr[123:60];
    endfunction

    // shift and subtract, one quotient bit per step
    function automatic logic [63:0] udiv64(logic [63:0] a, logic [63:0] b);
        logic [63:0] q;
        logic [64:0] rr;
        q  = '0;
        rr = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rr = {rr[63:0], a[i]};
            if (rr >= {1'b0, b})
            begin
                rr   = rr - {1'b0, b};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] exp_neg(int k);
        logic [63:0] num;
        logic [63:0] q;
        logic [63:0] rm;
        logic [63:0] r;
        logic [63:0] sum;
        logic [63:0] term;
        logic        stop;
        num  = 64'(k) << 48;
        q    = udiv64(num, 64'(TABLE_DEPTH));
        rm   = num - q * 64'(TABLE_DEPTH);
        r    = (q << 8) + udiv64(rm << 8, 64'(TABLE_DEPTH));
        sum  = Q60_ONE;
        term = Q60_ONE;
        stop = 1'b0;
        for (int n = 1; n <= 40; n++)
        begin
            if (!stop)
            begin
                term = udiv64(mul_q60(term, r), 64'(n));
                if (term == 64'd0)
                    stop = 1'b1;
                else if (n % 2 == 1)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
        end
        for (int i = 0; i < 8; i++)
        begin
            sum = mul_q60(sum, sum);
        end
        return sum;
    endfunction

    function automatic logic [TAB_W-1:0] tanh_entry(int k);
        logic [63:0] e;
        logic [63:0] nn;
        logic [63:0] dd;
        logic [63:0] t;
        e  = exp_neg(k);
        nn = (Q60_ONE - e) >> 20;
        dd = (Q60_ONE + e) >> 20;
        t  = udiv64(64'(2 * FULL_SCALE) * nn + dd, 64'd2 * dd);
        return TAB_W'(t);
    endfunction

    function automatic rom_t build_rom();
        logic [TAB_W-1:0] tv [TABLE_DEPTH+1];
        rom_t             rom;
        for (int k = 0; k <= TABLE_DEPTH; k++)
        begin
            tv[k] = tanh_entry(k);
        end
        for (int k = 0; k < ROM_N; k++)
        begin
            if (k < TABLE_DEPTH)
                rom[k] = {tv[k], TAB_W'(tv[k+1] - tv[k])};
            else
                rom[k] = '0;
        end
        return rom;
    endfunction

    localparam rom_t TANH_ROM = build_rom();

    ctrl_t            ctrl_reg;
    word_t            word_reg;
    logic [TAB_W-1:0] r1_reg;
    logic [E-1:0]     low_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= TANH_ROM[idx];
        r1_reg   <= r1_in;
        low_reg  <= low_in;
    end

    assign ctrl_out = ctrl_reg;
    assign t0       = word_reg[2*TAB_W-1:TAB_W];
    assign dt       = word_reg[TAB_W-1:0];
    assign r1_out   = r1_reg;
    assign low_out  = low_reg;

endmodule

`default_nettype wire

// ===== sv/gtsc_interp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gtsc_interp #(
    parameter int GAIN_FRAC_BITS = gtsc_pkg::DEF_GAIN_FRAC_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gtsc_pkg::ctrl_t               ctrl_in,
    input  logic [gtsc_pkg::TAB_W-1:0]    t0,
    input  logic [gtsc_pkg::TAB_W-1:0]    dt,
    input  logic [gtsc_pkg::TAB_W-1:0]    r1,
    input  logic [GAIN_FRAC_BITS+2:0]     low,
    output logic                          done,
    output logic [gtsc_pkg::SAMPLE_W-1:0] sample_out
);
    import gtsc_pkg::*;

    localparam int E   = GAIN_FRAC_BITS + 3;
    localparam int PAW = 2 * TAB_W;
    localparam int PBW = TAB_W + E + 1;
    localparam int WW  = PAW + 1;
    localparam int QW  = WW - TAB_W;
    localparam int FW  = QW + 1;
    localparam int MW  = FW + 1;
    localparam logic [PBW-1:0] BIAS = PBW'(FULL_SCALE) << (E - 1);

    ctrl_t            ctrl5_reg;
    ctrl_t            ctrl6_reg;
    ctrl_t            ctrl7_reg;
    logic [PAW-1:0]   pa_reg;
    logic [PBW-1:0]   pb_reg;
    logic [TAB_W-1:0] t0_5_reg;
    logic [TAB_W-1:0] t0_6_reg;
    logic [TAB_W-1:0] t0_7_reg;
    logic [WW-1:0]    w_reg;
    logic [WW-1:0]    w_next;
    logic [QW-1:0]    q0;
    logic [QW:0]      r0;
    logic [FW-1:0]    frac_reg;
    logic [FW-1:0]    frac_next;
    logic [MW-1:0]    m_sum;
    logic [TAB_W-1:0] m_mag;
    logic             done_reg;
    logic [SAMPLE_W-1:0] out_reg;
    logic [SAMPLE_W-1:0] out_next;

    always_comb
    begin
        w_next    = WW'(pa_reg) + WW'(pb_reg >> E);
        q0        = w_reg[WW-1:TAB_W];
        r0        = (QW+1)'(w_reg[TAB_W-1:0]) + (QW+1)'(q0);
        frac_next = FW'(q0) + FW'(r0 >= (QW+1)'(FULL_SCALE));
        m_sum     = MW'(t0_7_reg) + MW'(frac_reg);
        if (ctrl7_reg.sat || (m_sum > MW'(FULL_SCALE)))
            m_mag = TAB_W'(FULL_SCALE);
        else
            m_mag = m_sum[TAB_W-1:0];
        out_next = ctrl7_reg.neg ? (SAMPLE_W'(0) - SAMPLE_W'(m_mag)) : SAMPLE_W'(m_mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl5_reg <= '0;
            ctrl6_reg <= '0;
            ctrl7_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            ctrl5_reg <= ctrl_in;
            ctrl6_reg <= ctrl5_reg;
            ctrl7_reg <= ctrl6_reg;
            done_reg  <= ctrl7_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        pa_reg   <= PAW'(dt) * PAW'(r1);
        pb_reg   <= PBW'(dt) * PBW'(low) + BIAS;
        t0_5_reg <= t0;
        t0_6_reg <= t0_5_reg;
        t0_7_reg <= t0_6_reg;
        w_reg    <= w_next;
        frac_reg <= frac_next;
        out_reg  <= out_next;
    end

    assign done       = done_reg;
    assign sample_out = out_reg;

endmodule

`default_nettype wire

// ===== sv/gtsc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gtsc_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [gtsc_pkg::SAMPLE_W-1:0] sample_in,
    input  logic                          done,
    input  logic [gtsc_pkg::SAMPLE_W-1:0] sample_out
);
    import gtsc_pkg::*;

    localparam logic [SAMPLE_W-1:0] MOST_NEG = {1'b1, {(SAMPLE_W-1){1'b0}}};

    a_beat_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_LATENCY done
    ) else $error("accepted beat produced no result");

    a_result_has_beat: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_LATENCY)
    ) else $error("result without a matching input beat");

    a_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> (sample_out != MOST_NEG)
    ) else $error("result outside the clip range");

    a_sign: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && (sample_out != '0)) |->
            (sample_out[SAMPLE_W-1] == $past(sample_in[SAMPLE_W-1], PIPE_LATENCY))
    ) else $error("result sign differs from input sign");

endmodule

bind gain_tanh_soft_clipper gtsc_checker u_gtsc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .sample_in  (sample_in),
    .done       (done),
    .sample_out (sample_out)
);

`default_nettype wire
